[design/clnc_pkg.sv]
// Shared types, command codes and constants for the character LCD command sequencer.
// Used by the front end, the job queue, the strobe generator and the top level.
`timescale 1ns / 1ps

package clnc_pkg;

	typedef enum logic [2:0] {
		FUNC_INIT       = 3'd0,
		FUNC_CLEAR      = 3'd1,
		FUNC_CURSOR_OFF = 3'd2,
		FUNC_CURSOR_ON  = 3'd3,
		FUNC_GOTO       = 3'd4,
		FUNC_CHAR       = 3'd5,
		FUNC_WRAP_START = 3'd6,
		FUNC_WRAP_CHAR  = 3'd7
	} func_t;

	typedef enum logic {
		CFG_LINE_COUNT     = 1'b0,
		CFG_CHARS_PER_LINE = 1'b1
	} cfg_index_t;

	localparam logic [7:0] SET_ADDR       = 8'h80;
	localparam logic [7:0] ODD_ROW_OFFSET = 8'd20;
	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
	localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
	localparam logic [7:0] CMD_CURSOR_ON  = 8'h0F;
	localparam logic [7:0] CMD_FUNC_SET   = 8'h20;
	localparam logic [7:0] FUNC_SET_2LINE = 8'h08;
	localparam logic [3:0] NIB_8BIT       = 4'h3;
	localparam logic [3:0] NIB_4BIT       = 4'h2;
	localparam logic [3:0] HOLD_STD       = 4'd5;
	localparam logic [3:0] HOLD_CLEAR     = 4'd15;
	localparam logic [3:0] INIT_LAST_STEP = 4'd11;

	localparam logic [2:0] LINE_COUNT_RESET     = 3'd2;
	localparam logic [5:0] CHARS_PER_LINE_RESET = 6'd16;

	localparam int JOBQ_DEPTH = 4;
	localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

	// One classified command, as handed from the front end to the strobe generator.
	typedef struct packed {
		logic       init;        // full power-on sequence
		logic       two_line;    // function set carries the two-line bit
		logic [7:0] byte_a;      // first byte
		logic       rs_a;        // register select of the first byte
		logic       clear_hold;  // long hold after the first byte's low nibble
		logic       has_b;       // a second (command) byte follows
		logic [7:0] byte_b;      // second byte, always to the command register
	} job_t;

	// Nibble of the initialisation sequence at a given strobe.
	function automatic logic [3:0] init_nibble(input logic [3:0] step, input logic two_line);
		logic [7:0] bval;
		logic [3:0] idx;
		idx = step - 4'd4;
		case (idx[2:1])
			2'd0:    bval = two_line ? (CMD_FUNC_SET | FUNC_SET_2LINE) : CMD_FUNC_SET;
			2'd1:    bval = CMD_ENTRY_MODE;
			2'd2:    bval = CMD_DISP_ON;
			default: bval = CMD_CLEAR;
		endcase
		if (step < 4'd3) begin
			return NIB_8BIT;
		end else if (step == 4'd3) begin
			return NIB_4BIT;
		end else begin
			return idx[0] ? bval[3:0] : bval[7:4];
		end
	endfunction

endpackage

[design/clnc_front.sv]
// Front end: configuration registers, wrap counters and command classification.
// Depends on clnc_pkg.
`timescale 1ns / 1ps

module clnc_front import clnc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [5:0] cfg_data,
	input  logic       accept,
	input  logic [2:0] func,
	input  logic [6:0] column,
	input  logic [1:0] row,
	input  logic [7:0] char_code,
	output job_t       job
);

	logic [2:0] line_count_q;
	logic [5:0] chars_per_line_q;
	logic [5:0] wrap_column_q;
	logic [7:0] wrap_line_q;
	logic [5:0] wrap_column_d;
	logic [7:0] wrap_line_d;
	logic [5:0] col_inc;

	// Set-address command byte for a column and line under the current layout.
	function automatic logic [7:0] goto_addr(input logic [6:0] col, input logic [7:0] line,
			input logic [2:0] lc);
		logic [7:0] base;
		logic [7:0] lm1;
		lm1 = line - 8'd1;
		if (lc == 3'd2) begin
			base = {line[1:0], 6'b0};
		end else if (lc == 3'd4) begin
			if (line == 8'd0 || line == 8'd2) begin
				base = {line[2:1], 6'b0};
			end else begin
				base = {lm1[2:1], 6'b0} + ODD_ROW_OFFSET;
			end
		end else begin
			base = 8'd0;
		end
		return base + {1'b0, col} + SET_ADDR;
	endfunction

	assign col_inc = wrap_column_q + 6'd1;

	always_comb begin
		job = '0;
		wrap_column_d = wrap_column_q;
		wrap_line_d = wrap_line_q;
		case (func_t'(func))
			FUNC_INIT: begin
				job.init = 1'b1;
				job.two_line = (line_count_q == 3'd2);
			end
			FUNC_CLEAR: begin
				job.byte_a = CMD_CLEAR;
				job.clear_hold = 1'b1;
			end
			FUNC_CURSOR_OFF: job.byte_a = CMD_DISP_ON;
			FUNC_CURSOR_ON:  job.byte_a = CMD_CURSOR_ON;
			FUNC_GOTO:       job.byte_a = goto_addr(column, {6'b0, row}, line_count_q);
			FUNC_CHAR: begin
				job.byte_a = char_code;
				job.rs_a = 1'b1;
			end
			FUNC_WRAP_START: begin
				job.byte_a = goto_addr(7'd0, 8'd0, line_count_q);
				wrap_column_d = 6'd0;
				wrap_line_d = 8'd0;
			end
			default: begin
				job.byte_a = char_code;
				job.rs_a = 1'b1;
				wrap_column_d = col_inc;
				if (col_inc == chars_per_line_q) begin
					wrap_column_d = 6'd0;
					if (wrap_line_q != 8'hFF) begin
						wrap_line_d = wrap_line_q + 8'd1;
					end
					job.has_b = 1'b1;
					job.byte_b = goto_addr(7'd0, wrap_line_d, line_count_q);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= LINE_COUNT_RESET;
			chars_per_line_q <= CHARS_PER_LINE_RESET;
			wrap_column_q <= 6'd0;
			wrap_line_q <= 8'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_LINE_COUNT: line_count_q <= cfg_data[2:0];
					default:        chars_per_line_q <= cfg_data;
				endcase
			end
			if (accept) begin
				wrap_column_q <= wrap_column_d;
				wrap_line_q <= wrap_line_d;
			end
		end
	end

endmodule

[design/clnc_jobq.sv]
// Short job queue between the front end and the strobe generator.
// Depends on clnc_pkg for the job record and depth.
`timescale 1ns / 1ps

module clnc_jobq import clnc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	input  logic rd_en,
	output job_t rd_data,
	output logic full,
	output logic empty
);

	job_t                  mem [JOBQ_DEPTH];
	logic [JOBQ_AW-1:0]    wr_ptr_q;
	logic [JOBQ_AW-1:0]    rd_ptr_q;
	logic [JOBQ_AW:0]      count_q;

	assign full = (count_q == (JOBQ_AW+1)'(JOBQ_DEPTH));
	assign empty = (count_q == '0);
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + JOBQ_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + JOBQ_AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + (JOBQ_AW+1)'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - (JOBQ_AW+1)'(1);
			end
		end
	end

endmodule

[design/clnc_strobe.sv]
// Strobe generator: expands queued jobs into one nibble transfer per cycle
// while its registered result slot is free. Depends on clnc_pkg.
`timescale 1ns / 1ps

module clnc_strobe import clnc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       q_data,
	input  logic       q_empty,
	output logic       q_pop,
	input  logic       pop,
	output logic       empty,
	output logic [3:0] nibble,
	output logic       reg_select,
	output logic [3:0] hold_ms,
	output logic       last
);

	job_t       job_q;
	logic       active_q;
	logic [3:0] step_q;
	logic       out_valid_q;
	logic [3:0] nibble_q;
	logic       rs_q;
	logic [3:0] hold_q;
	logic       last_q;

	logic       slot_free;
	logic       advance;
	logic [3:0] nib_d;
	logic       rs_d;
	logic [3:0] hold_d;
	logic       last_d;

	assign slot_free = !out_valid_q || pop;
	assign advance = active_q && slot_free;
	assign q_pop = (!active_q || (advance && last_d)) && !q_empty;

	always_comb begin
		nib_d = 4'h0;
		rs_d = 1'b0;
		hold_d = HOLD_STD;
		last_d = 1'b0;
		if (job_q.init) begin
			nib_d = init_nibble(step_q, job_q.two_line);
			last_d = (step_q == INIT_LAST_STEP);
			hold_d = last_d ? HOLD_CLEAR : HOLD_STD;
		end else begin
			case (step_q[1:0])
				2'd0: begin
					nib_d = job_q.byte_a[7:4];
					rs_d = job_q.rs_a;
				end
				2'd1: begin
					nib_d = job_q.byte_a[3:0];
					rs_d = job_q.rs_a;
					hold_d = job_q.clear_hold ? HOLD_CLEAR : HOLD_STD;
					last_d = !job_q.has_b;
				end
				2'd2: nib_d = job_q.byte_b[7:4];
				default: begin
					nib_d = job_q.byte_b[3:0];
					last_d = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_data;
		end
		if (advance) begin
			nibble_q <= nib_d;
			rs_q <= rs_d;
			hold_q <= hold_d;
			last_q <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				active_q <= 1'b1;
				step_q <= 4'd0;
			end else if (advance) begin
				active_q <= !last_d;
				step_q <= step_q + 4'd1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty = !out_valid_q;
	assign nibble = nibble_q;
	assign reg_select = rs_q;
	assign hold_ms = hold_q;
	assign last = last_q;

endmodule

[design/char_lcd_nibble_command_sequencer.sv]
// Top level of the character LCD 4-bit bus command sequencer.
// Depends on clnc_pkg, clnc_front, clnc_jobq and clnc_strobe.
`timescale 1ns / 1ps

// Each command pushed in becomes the ordered list of enable strobes that a
// 4-bit character LCD bus needs: init gives twelve, a wrapped character that
// ends a line gives four, every other command two. Every transaction on the
// result side is one strobe, carrying the nibble for DB7..DB4, the register
// select level, the hold time in milliseconds to wait afterwards and a flag
// on the command's final strobe. Commands are taken one per cycle while the
// four-entry job queue has room; the strobe generator behind it delivers one
// strobe per cycle while the reader keeps popping, so the sustained rate is
// set by the strobe count of each command and not by the front end. The
// result slot is a register, so a waiting strobe stops the front from
// accepting commands only once the job queue is full. Configuration (line
// count, characters per line) may be written through its own channel, which
// is always ready; it should only be changed while no command is in flight.

module char_lcd_nibble_command_sequencer import clnc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [5:0] cfg_data,
	// command side
	input  logic       push,
	output logic       full,
	input  logic [2:0] func,
	input  logic [6:0] column,
	input  logic [1:0] row,
	input  logic [7:0] char_code,
	// strobe side
	output logic       empty,
	input  logic       pop,
	output logic [3:0] nibble,
	output logic       reg_select,
	output logic [3:0] hold_ms,
	output logic       last
);

	job_t front_job;
	job_t head_job;
	logic accept;
	logic q_full;
	logic q_empty;
	logic q_pop;

	// The configuration registers never back-pressure a write.
	assign cfg_ready = 1'b1;
	assign full = q_full;
	// A command transaction completes when the queue can take its job.
	assign accept = push && !q_full;

	clnc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.func      (func),
		.column    (column),
		.row       (row),
		.char_code (char_code),
		.job       (front_job)
	);

	clnc_jobq u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (front_job),
		.rd_en   (q_pop),
		.rd_data (head_job),
		.full    (q_full),
		.empty   (q_empty)
	);

	clnc_strobe u_strobe (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_data     (head_job),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.nibble     (nibble),
		.reg_select (reg_select),
		.hold_ms    (hold_ms),
		.last       (last)
	);

endmodule

[tb/char_lcd_nibble_command_sequencer_test.sv]
// Self-checking testbench for the character LCD 4-bit bus command sequencer.
// Depends on clnc_pkg and char_lcd_nibble_command_sequencer with its submodules.
`timescale 1ns / 1ps

// Commands are queued by the stimulus process and handed to the block by a
// driver that works on the falling edge. A monitor on the rising edge does
// two jobs. For every command transaction it works out the enable strobes
// that the command should produce and appends them to a queue of expected
// strobes. For every strobe transaction it compares the strobe, field by
// field, with the oldest expected strobe. Both sides idle at random, and the
// strobe reader can be told to hold off for a long stretch so that the job
// queue fills up and the block has to raise full.
module char_lcd_nibble_command_sequencer_test import clnc_pkg::*;;

	localparam int QUIET_LIMIT = 2000;  // cycles without any transaction
	localparam int LONG_STALL  = 150;   // cycles of the receiver's long hold-off
	localparam int END_DRAIN   = 40;    // cycles to wait for strays at the end

	// One enable strobe as the block presents it on the result side.
	typedef struct packed {
		logic [3:0] nibble;
		logic       rs;
		logic [3:0] hold;
		logic       last;
	} strobe_t;

	// One command as pushed into the block.
	typedef struct packed {
		logic [2:0] func;
		logic [6:0] column;
		logic [1:0] row;
		logic [7:0] ch;
	} lcd_cmd_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       cfg_valid  = 1'b0;
	logic       cfg_ready;
	logic       cfg_index  = 1'b0;
	logic [5:0] cfg_data   = '0;
	logic       push       = 1'b0;
	logic       full;
	logic [2:0] func       = '0;
	logic [6:0] column     = '0;
	logic [1:0] row        = '0;
	logic [7:0] char_code  = '0;
	logic       empty;
	logic       pop        = 1'b0;
	logic [3:0] nibble;
	logic       reg_select;
	logic [3:0] hold_ms;
	logic       last;

	// The testbench's own copy of the configuration and the wrap counters.
	logic [2:0] line_count_q     = LINE_COUNT_RESET;
	logic [5:0] chars_per_line_q = CHARS_PER_LINE_RESET;
	logic [5:0] wrap_col_q       = '0;
	logic [7:0] wrap_line_q      = '0;

	lcd_cmd_t pending_cmds[$];
	strobe_t  expected_strobes[$];

	int  cmds_queued     = 0;
	int  cmds_accepted   = 0;
	int  strobes_checked = 0;
	int  cfg_writes      = 0;
	int  mismatch_count  = 0;
	int  cmd_gap         = 0;
	int  pop_gap         = 0;
	int  stall_left      = 0;
	bit  idle_on         = 1'b1;
	bit  stall_req       = 1'b0;
	bit  cmd_taken       = 1'b0;
	bit  strobe_taken    = 1'b0;

	char_lcd_nibble_command_sequencer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.func       (func),
		.column     (column),
		.row        (row),
		.char_code  (char_code),
		.empty      (empty),
		.pop        (pop),
		.nibble     (nibble),
		.reg_select (reg_select),
		.hold_ms    (hold_ms),
		.last       (last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction of the strobes that one command produces.
	// ------------------------------------------------------------------

	task automatic add_strobe(logic [3:0] nib, logic rs, logic [3:0] hold);
		strobe_t s;
		s.nibble = nib;
		s.rs     = rs;
		s.hold   = hold;
		s.last   = 1'b0;
		expected_strobes.push_back(s);
	endtask

	// A full byte goes out high nibble first; only the low nibble may carry
	// the long hold that a clear needs.
	task automatic add_byte(logic [7:0] b, logic rs, logic [3:0] low_hold);
		add_strobe(b[7:4], rs, HOLD_STD);
		add_strobe(b[3:0], rs, low_hold);
	endtask

	// Set-address command. The line may be the full 8-bit wrap line, so the
	// address is worked out wide and then cut to its low byte, as the bus does.
	task automatic add_goto(int col, int line);
		int addr;
		if (line_count_q == 3'd2) begin
			addr = 64 * line + col;
		end else if (line_count_q == 3'd4) begin
			// In the four-line layout lines 1 and 3 continue lines 0 and 2 at
			// an offset of twenty, and any wrap line that is not 0 or 2 counts
			// as one of the odd lines.
			if (line == 0 || line == 2) begin
				addr = 64 * (line / 2) + col;
			end else begin
				addr = 64 * ((line - 1) / 2) + ODD_ROW_OFFSET + col;
			end
		end else begin
			addr = col;
		end
		addr = addr + SET_ADDR;
		add_byte(addr[7:0], 1'b0, HOLD_STD);
	endtask

	task automatic predict_strobes(lcd_cmd_t c);
		strobe_t s;
		case (func_t'(c.func))
			FUNC_INIT: begin
				// Three 8-bit function sets, the switch to 4-bit, then the
				// usual set-up bytes ending with a clear.
				add_strobe(NIB_8BIT, 1'b0, HOLD_STD);
				add_strobe(NIB_8BIT, 1'b0, HOLD_STD);
				add_strobe(NIB_8BIT, 1'b0, HOLD_STD);
				add_strobe(NIB_4BIT, 1'b0, HOLD_STD);
				add_byte((line_count_q == 3'd2) ? (CMD_FUNC_SET | FUNC_SET_2LINE) : CMD_FUNC_SET,
					1'b0, HOLD_STD);
				add_byte(CMD_ENTRY_MODE, 1'b0, HOLD_STD);
				add_byte(CMD_DISP_ON, 1'b0, HOLD_STD);
				add_byte(CMD_CLEAR, 1'b0, HOLD_CLEAR);
			end
			FUNC_CLEAR:      add_byte(CMD_CLEAR, 1'b0, HOLD_CLEAR);
			FUNC_CURSOR_OFF: add_byte(CMD_DISP_ON, 1'b0, HOLD_STD);
			FUNC_CURSOR_ON:  add_byte(CMD_CURSOR_ON, 1'b0, HOLD_STD);
			FUNC_GOTO:       add_goto(c.column, c.row);
			FUNC_CHAR:       add_byte(c.ch, 1'b1, HOLD_STD);
			FUNC_WRAP_START: begin
				wrap_col_q  = '0;
				wrap_line_q = '0;
				add_goto(0, 0);
			end
			default: begin
				// Wrapped character. The column counter is six bits wide, so a
				// width of zero behaves as sixty-four, and a column already past
				// the width runs round before it can break the line.
				add_byte(c.ch, 1'b1, HOLD_STD);
				wrap_col_q = wrap_col_q + 6'd1;
				if (wrap_col_q == chars_per_line_q) begin
					wrap_col_q = '0;
					if (wrap_line_q != 8'd255) begin
						wrap_line_q = wrap_line_q + 8'd1;
					end
					add_goto(0, wrap_line_q);
				end
			end
		endcase
		// Every command produces at least two strobes, so the newest one
		// belongs to this command and carries the last flag.
		s = expected_strobes.pop_back();
		s.last = 1'b1;
		expected_strobes.push_back(s);
	endtask

	task automatic report_mismatch(string what);
		$display("ERROR %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	// Mostly short gaps, now and then a long one; none while idling is off.
	function automatic int pick_gap();
		int r;
		if (!idle_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(12, 40);
	endfunction

	// ------------------------------------------------------------------
	// Driver, strobe reader and monitor.
	// ------------------------------------------------------------------

	// The command driver keeps push high until the transaction has happened,
	// then either offers the next command or idles for a while.
	always @(negedge clk) begin : cmd_driver
		lcd_cmd_t c;
		if (!push || cmd_taken) begin
			if (cmd_gap > 0) begin
				push    <= 1'b0;
				cmd_gap <= cmd_gap - 1;
			end else if (pending_cmds.size() == 0) begin
				push <= 1'b0;
			end else begin
				c = pending_cmds.pop_front();
				func      <= c.func;
				column    <= c.column;
				row       <= c.row;
				char_code <= c.ch;
				push      <= 1'b1;
				cmd_gap   <= pick_gap();
			end
		end
	end

	// The strobe reader. A hold-off request takes priority over everything
	// and is counted out here, while the driver keeps offering commands.
	always @(negedge clk) begin : strobe_reader
		int g;
		if (stall_left > 0) begin
			pop        <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_req) begin
			pop        <= 1'b0;
			stall_left <= LONG_STALL;
			stall_req  <= 1'b0;
		end else if (pop_gap > 0) begin
			pop     <= 1'b0;
			pop_gap <= pop_gap - 1;
		end else if (strobe_taken) begin
			g = pick_gap();
			pop     <= (g == 0);
			pop_gap <= (g == 0) ? 0 : g - 1;
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin : bus_monitor
		lcd_cmd_t c;
		strobe_t  want;
		if (!arst_n) begin
			cmd_taken    <= 1'b0;
			strobe_taken <= 1'b0;
		end else begin
			cmd_taken    <= push && !full;
			strobe_taken <= pop && !empty;
			if (pop && !empty) begin
				strobes_checked++;
				if (expected_strobes.size() == 0) begin
					report_mismatch($sformatf("strobe %0d arrived with none expected",
						strobes_checked));
				end else begin
					want = expected_strobes.pop_front();
					if (nibble !== want.nibble)
						report_mismatch($sformatf("strobe %0d nibble %h, expected %h",
							strobes_checked, nibble, want.nibble));
					if (reg_select !== want.rs)
						report_mismatch($sformatf("strobe %0d reg_select %b, expected %b",
							strobes_checked, reg_select, want.rs));
					if (hold_ms !== want.hold)
						report_mismatch($sformatf("strobe %0d hold_ms %0d, expected %0d",
							strobes_checked, hold_ms, want.hold));
					if (last !== want.last)
						report_mismatch($sformatf("strobe %0d last %b, expected %b",
							strobes_checked, last, want.last));
				end
			end
			if (push && !full) begin
				c.func   = func;
				c.column = column;
				c.row    = row;
				c.ch     = char_code;
				predict_strobes(c);
				cmds_accepted++;
			end
		end
	end

	// The watchdog ends the run once nothing has moved for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Run stalled: no transaction for %0d cycles.", QUIET_LIMIT);
		$display("char_lcd_nibble_command_sequencer: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus.
	// ------------------------------------------------------------------

	// Commands are queued on the rising edge so that the driver, which works
	// on the falling edge, never races with the queue being filled.
	task automatic add_cmd(func_t f, logic [6:0] col, logic [1:0] r, logic [7:0] ch);
		lcd_cmd_t c;
		c.func   = f;
		c.column = col;
		c.row    = r;
		c.ch     = ch;
		pending_cmds.push_back(c);
		cmds_queued++;
	endtask

	task automatic add_random_cmd(int wrap_pct, bit allow_wrap_start);
		func_t f;
		if ($urandom_range(0, 99) < wrap_pct) begin
			f = FUNC_WRAP_CHAR;
		end else begin
			f = func_t'($urandom_range(0, 6));
		end
		// A wrap start would undo a long run that is meant to build up the
		// counters, so such runs send a plain character instead.
		if (!allow_wrap_start && f == FUNC_WRAP_START) begin
			f = FUNC_CHAR;
		end
		add_cmd(f, 7'($urandom_range(0, 127)), 2'($urandom_range(0, 3)),
			8'($urandom_range(0, 255)));
	endtask

	// Idle means every command has been taken and every strobe has come.
	task automatic wait_idle();
		@(negedge clk);
		while (cmds_accepted != cmds_queued || expected_strobes.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_reg(cfg_index_t idx, logic [5:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		if (idx == CFG_LINE_COUNT) begin
			line_count_q = val[2:0];
		end else begin
			chars_per_line_q = val;
		end
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One phase: wait until the block is idle, set both registers, then queue
	// a batch of random commands with the given share of wrapped characters.
	task automatic run_phase(logic [2:0] lines, logic [5:0] width, int count, int wrap_pct,
			bit allow_wrap_start, bit lead_wrap_start, bit idling, bit hold_off);
		wait_idle();
		write_reg(CFG_LINE_COUNT, {3'b000, lines});
		write_reg(CFG_CHARS_PER_LINE, width);
		@(posedge clk);
		idle_on = idling;
		if (hold_off) begin
			stall_req = 1'b1;
		end
		if (lead_wrap_start) begin
			add_cmd(FUNC_WRAP_START, 7'($urandom_range(0, 127)), 2'($urandom_range(0, 3)),
				8'($urandom_range(0, 255)));
		end
		repeat (count) add_random_cmd(wrap_pct, allow_wrap_start);
	endtask

	initial begin : stimulus
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed commands under the reset configuration (two lines, sixteen
		// characters). Fields that a command ignores are set to odd values.
		add_cmd(FUNC_INIT, 7'd127, 2'd3, 8'hFF);
		add_cmd(FUNC_CLEAR, 7'd0, 2'd0, 8'h00);
		add_cmd(FUNC_CURSOR_OFF, 7'd85, 2'd2, 8'hAA);
		add_cmd(FUNC_CURSOR_ON, 7'd42, 2'd1, 8'h55);
		add_cmd(FUNC_GOTO, 7'd0, 2'd0, 8'hFF);
		add_cmd(FUNC_GOTO, 7'd127, 2'd3, 8'h00);
		add_cmd(FUNC_GOTO, 7'd63, 2'd1, 8'h12);
		add_cmd(FUNC_CHAR, 7'd127, 2'd3, 8'h00);
		add_cmd(FUNC_CHAR, 7'd0, 2'd0, 8'hFF);
		add_cmd(FUNC_WRAP_START, 7'd127, 2'd3, 8'hFF);

		// Four lines of forty characters; the receiver holds off at the start.
		run_phase(3'd4, 6'd40, 12, 30, 1'b1, 1'b0, 1'b1, 1'b1);
		// One character per line until the line counter saturates, with a
		// second long hold-off of the receiver.
		run_phase(3'd2, 6'd1, 257, 100, 1'b0, 1'b1, 1'b1, 1'b1);
		// Register extremes that fall back to the one-line layout.
		run_phase(3'd7, 6'd0, 5, 50, 1'b1, 1'b0, 1'b0, 1'b0);
		run_phase(3'd0, 6'd2, 5, 50, 1'b1, 1'b0, 1'b1, 1'b0);

		wait_idle();
		repeat (END_DRAIN) @(posedge clk);

		$display("Sent %0d commands and checked %0d strobes across %0d register writes.",
			cmds_accepted, strobes_checked, cfg_writes);
		$display("Layouts of one, two and four lines, line breaks on wrapped text and line");
		$display("counter saturation were exercised under random idling and back-pressure.");
		if (mismatch_count == 0) begin
			$display("char_lcd_nibble_command_sequencer: match");
		end else begin
			$display("char_lcd_nibble_command_sequencer: mismatch");
		end
		$finish;
	end

endmodule
